// File: hdl/lrupr_pkg.sv
// shared constants for the lru page replacement block
`timescale 1ns / 1ps

package lrupr_pkg;

  localparam int NUM_FRAMES_DEF = 8;
  localparam int PAGE_BITS_DEF  = 16;
  localparam int PAGE_IN_W      = 16;
  localparam int CFG_W          = 4;
  localparam int FAULT_W        = 32;

endpackage

// File: hdl/lru_page_replacement.sv
// lru page replacement over a fully associative set of page frames
`timescale 1ns / 1ps

// One page reference is taken per cycle. busy_o is always low. Each reference
// gives exactly one result. The reference is captured in the input register,
// and its result then goes to the result register: done_o is high for a
// single cycle per reference and the result ports hold until the next result.
// While in the input register, the frame compare, the oldest-frame search and
// the recency update all settle in one pass. The result register and the frame
// state are written at the same edge, so the next reference sees the updated frames.
// Results cannot be held off by the receiver.
module lru_page_replacement #(
  parameter int NUM_FRAMES = lrupr_pkg::NUM_FRAMES_DEF,
  parameter int PAGE_BITS  = lrupr_pkg::PAGE_BITS_DEF,
  parameter int FRAME_W    = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lrupr_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [lrupr_pkg::PAGE_IN_W-1:0]     page_number_i,
  input  logic                                restart_i,
  output logic                                done_o,
  output logic                                hit_o,
  output logic [FRAME_W-1:0]                  frame_index_o,
  output logic                                evicted_valid_o,
  output logic [lrupr_pkg::PAGE_IN_W-1:0]     evicted_page_o,
  output logic [lrupr_pkg::FAULT_W-1:0]       fault_count_o
);
  import lrupr_pkg::*;

  localparam int PW     = (PAGE_BITS < PAGE_IN_W) ? PAGE_BITS : PAGE_IN_W;
  localparam int RW     = FRAME_W;
  localparam int CNT_NW = $clog2(NUM_FRAMES + 1);
  localparam int CW     = (CNT_NW > CFG_W) ? CNT_NW : CFG_W;
  localparam logic [RW-1:0]      RANK_MAX  = RW'(NUM_FRAMES - 1);
  localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

  logic                  in_valid_q;
  logic [PW-1:0]         page_q;
  logic                  restart_q;
  logic [CW-1:0]         frames_q;

  logic [PW-1:0]         frame_page_q [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] valid_q, valid_d, valid_eff;
  logic [RW-1:0]         rank_q [NUM_FRAMES];
  logic [RW-1:0]         rank_d [NUM_FRAMES];
  logic [RW-1:0]         rank_eff [NUM_FRAMES];
  logic [FAULT_W-1:0]    faults_q, faults_d, faults_eff;

  logic [NUM_FRAMES-1:0] act, match, free, cand;
  logic                  hit_any, free_any;
  logic [FRAME_W-1:0]    hit_idx, free_idx, vic_idx, tgt;
  logic [RW-1:0]         rank_hit;
  logic [PW-1:0]         evict_page;

  logic                  done_q, hit_q, ev_q;
  logic [FRAME_W-1:0]    idx_q;
  logic [PAGE_IN_W-1:0]  evp_q;
  logic [FAULT_W-1:0]    cnt_q;

  assign busy_o = 1'b0;

  // active frames, restart applied, match and free search
  always_comb begin
    valid_eff  = restart_q ? '0 : valid_q;
    faults_eff = restart_q ? '0 : faults_q;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      act[i]      = (i == 0) || (i < int'(frames_q));
      rank_eff[i] = restart_q ? '0 : rank_q[i];
      match[i]    = act[i] && valid_eff[i] && (frame_page_q[i] == page_q);
      free[i]     = act[i] && !valid_eff[i];
    end
  end

  // oldest active frame, lowest index on equal rank
  always_comb begin
    for (int i = 0; i < NUM_FRAMES; i++) begin
      cand[i] = act[i];
      for (int j = 0; j < NUM_FRAMES; j++) begin
        if (j != i && act[j]) begin
          if (j < i) begin
            cand[i] = cand[i] && (rank_eff[i] > rank_eff[j]);
          end else begin
            cand[i] = cand[i] && (rank_eff[i] >= rank_eff[j]);
          end
        end
      end
    end
  end

  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    vic_idx  = '0;
    for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_any = 1'b1;
        hit_idx = FRAME_W'(i);
      end
      if (free[i]) begin
        free_any = 1'b1;
        free_idx = FRAME_W'(i);
      end
      if (cand[i]) begin
        vic_idx = FRAME_W'(i);
      end
    end
  end

  assign tgt        = hit_any ? hit_idx : (free_any ? free_idx : vic_idx);
  assign rank_hit   = rank_eff[hit_idx];
  assign evict_page = frame_page_q[vic_idx];

  // recency update and fault count
  always_comb begin
    valid_d = valid_eff;
    if (!hit_any) begin
      valid_d[tgt] = 1'b1;
    end
    for (int i = 0; i < NUM_FRAMES; i++) begin
      rank_d[i] = rank_eff[i];
      if (FRAME_W'(i) == tgt) begin
        rank_d[i] = '0;
      end else if (act[i] && valid_eff[i] && (!hit_any || rank_eff[i] < rank_hit)
                   && rank_eff[i] != RANK_MAX) begin
        rank_d[i] = rank_eff[i] + 1'b1;
      end
    end
    faults_d = faults_eff;
    if (!hit_any && faults_eff != FAULT_MAX) begin
      faults_d = faults_eff + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      frames_q   <= CW'(NUM_FRAMES);
      valid_q    <= '0;
      faults_q   <= '0;
      done_q     <= 1'b0;
      for (int i = 0; i < NUM_FRAMES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      in_valid_q <= start_i;
      done_q     <= in_valid_q;
      if (cfg_we_i) begin
        frames_q <= CW'(cfg_data_i);
      end
      if (in_valid_q) begin
        valid_q  <= valid_d;
        faults_q <= faults_d;
        for (int i = 0; i < NUM_FRAMES; i++) begin
          rank_q[i] <= rank_d[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      page_q    <= page_number_i[PW-1:0];
      restart_q <= restart_i;
    end
    if (in_valid_q) begin
      if (!hit_any) begin
        frame_page_q[tgt] <= page_q;
      end
      hit_q <= hit_any;
      idx_q <= tgt;
      ev_q  <= !hit_any && !free_any;
      evp_q <= (!hit_any && !free_any) ? PAGE_IN_W'(evict_page) : '0;
      cnt_q <= faults_d;
    end
  end

  assign done_o          = done_q;
  assign hit_o           = hit_q;
  assign frame_index_o   = idx_q;
  assign evicted_valid_o = ev_q;
  assign evicted_page_o  = evp_q;
  assign fault_count_o   = cnt_q;

endmodule
